// ===== design/top_k_rank_with_dedup_top_defines.svh =====
// ----------------------------------------------------------------------------
// Top-k rank list assertion macros
// Shared concurrent assertion forms for the ranked list design.
// ----------------------------------------------------------------------------
`ifndef TOP_K_RANK_WITH_DEDUP_TOP_DEFINES_SVH
`define TOP_K_RANK_WITH_DEDUP_TOP_DEFINES_SVH

// same-cycle implication
`define TKR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TKR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tkr_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-k rank list package
// Sizes, codes and the control types shared by the cell row and the top level.
// ----------------------------------------------------------------------------
package tkr_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int VAL_W       = 32;
	localparam int CNT_W       = 4;
	localparam int IDX_W       = 3;
	localparam int ST_W        = 3;
	localparam int CFG_IDX_W   = 1;

	localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [ST_W-1:0] ST_DROPPED   = 3'd1;
	localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [ST_W-1:0] ST_LIGHT     = 3'd3;
	localparam logic [ST_W-1:0] ST_DISABLED  = 3'd4;
	localparam logic [ST_W-1:0] ST_READ_OK   = 3'd5;
	localparam logic [ST_W-1:0] ST_BAD_INDEX = 3'd6;

	localparam logic ACT_OFFER = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;

	localparam logic [CNT_W-1:0] CAP_RESET = 4'd2;

	// per-cell update command
	typedef struct packed {
		logic ld_new;
		logic ld_prev;
	} tkr_cell_ctrl_t;

	// per-cell compare result
	typedef struct packed {
		logic match;
		logic heavier;
	} tkr_cell_flag_t;

endpackage

// ===== design/tkr_cell.sv =====
// ----------------------------------------------------------------------------
// Top-k rank list cell
// Holds one (key, weight) entry, compares it against the offered pair and
// loads either the offered pair or its left neighbor's entry on command.
// ----------------------------------------------------------------------------
module tkr_cell (
	input  logic                                 clk,
	input  logic signed [tkr_pkg::VAL_W-1:0]     key_in,
	input  logic        [tkr_pkg::VAL_W-1:0]     wt_in,
	input  logic        [tkr_pkg::VAL_W-1:0]     tol,
	input  logic signed [tkr_pkg::VAL_W-1:0]     prev_key,
	input  logic        [tkr_pkg::VAL_W-1:0]     prev_wt,
	input  tkr_pkg::tkr_cell_ctrl_t              ctrl,
	output logic signed [tkr_pkg::VAL_W-1:0]     key_out,
	output logic        [tkr_pkg::VAL_W-1:0]     wt_out,
	output tkr_pkg::tkr_cell_flag_t              flag
);
	import tkr_pkg::*;

	logic signed [VAL_W-1:0] key_q;
	logic        [VAL_W-1:0] wt_q;
	logic signed [VAL_W:0]   diff;
	logic        [VAL_W-1:0] key_gap;

	// exact |key_q - key_in|, one guard bit so it cannot wrap
	assign diff = {key_q[VAL_W-1], key_q} - {key_in[VAL_W-1], key_in};
	assign key_gap = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];

	assign flag.match   = (key_gap <= tol);
	assign flag.heavier = (wt_q >= wt_in);

	always_ff @(posedge clk) begin
		if (ctrl.ld_new) begin
			key_q <= key_in;
			wt_q  <= wt_in;
		end else if (ctrl.ld_prev) begin
			key_q <= prev_key;
			wt_q  <= prev_wt;
		end
	end

	assign key_out = key_q;
	assign wt_out  = wt_q;

endmodule

// ===== design/top_k_rank_with_dedup_top.sv =====
// An accepted item waits in the item stage until it is decided; its result is then
// registered and shown from then on, until the result side takes it.
// Throughput: one item per cycle unless the result side stalls; the cell row compares
// every entry in parallel and shifts the list in the same cycle that the item is decided.
// Reset: entry count, capacity (2), tolerance (0) and valid flags clear at once;
// the entry cells are not cleared, entries at or above the count are never read.
// ----------------------------------------------------------------------------
// Top-k rank list with key de-duplication
// Bounded list of (key, weight) pairs kept heaviest first in a row of cells,
// with tolerance-based duplicate rejection and indexed reads.
// ----------------------------------------------------------------------------
`include "top_k_rank_with_dedup_top_defines.svh"

module top_k_rank_with_dedup_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tkr_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [tkr_pkg::VAL_W-1:0]               cfg_data,
	// items
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    action,
	input  logic signed [tkr_pkg::VAL_W-1:0]        key_value,
	input  logic        [tkr_pkg::VAL_W-1:0]        weight_value,
	input  logic [tkr_pkg::IDX_W-1:0]               read_index,
	// results
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [tkr_pkg::ST_W-1:0]                status,
	output logic [tkr_pkg::CNT_W-1:0]               position,
	output logic [tkr_pkg::CNT_W-1:0]               entry_count,
	output logic signed [tkr_pkg::VAL_W-1:0]        entry_key,
	output logic        [tkr_pkg::VAL_W-1:0]        entry_weight
);
	import tkr_pkg::*;

	// configuration and list state
	logic [CNT_W-1:0] capacity_q;
	logic [VAL_W-1:0] tol_q;
	logic [CNT_W-1:0] count_q;

	// item stage
	logic                    vld_s1;
	logic                    act_s1;
	logic signed [VAL_W-1:0] key_s1;
	logic        [VAL_W-1:0] wt_s1;
	logic [IDX_W-1:0]        ridx_s1;

	// result register
	logic                    out_valid_q;
	logic [ST_W-1:0]         status_q;
	logic [CNT_W-1:0]        position_q;
	logic [CNT_W-1:0]        entry_count_q;
	logic signed [VAL_W-1:0] entry_key_q;
	logic        [VAL_W-1:0] entry_weight_q;

	// cell row
	logic signed [VAL_W-1:0] cell_key [MAX_ENTRIES];
	logic        [VAL_W-1:0] cell_wt  [MAX_ENTRIES];
	tkr_cell_flag_t          cell_flag [MAX_ENTRIES];
	tkr_cell_ctrl_t          cell_ctrl [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]  dup_vec;
	logic [MAX_ENTRIES-1:0]  hv_vec;

	// decision
	logic                    accept;
	logic                    commit;
	logic [CNT_W-1:0]        lim;
	logic [CNT_W-1:0]        last;
	logic [CNT_W-1:0]        dup_pos;
	logic [CNT_W-1:0]        ins_pos;
	logic                    do_ins;
	logic [ST_W-1:0]         st_nxt;
	logic [CNT_W-1:0]        pos_nxt;
	logic [CNT_W-1:0]        cnt_nxt;
	logic signed [VAL_W-1:0] okey;
	logic        [VAL_W-1:0] owt;

	assign cfg_ready = 1'b1;
	assign commit    = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !vld_s1 || commit;
	assign accept    = in_valid && in_ready;

	assign lim = (capacity_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : capacity_q;

	genvar g;
	generate
		for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
			logic signed [VAL_W-1:0] pk;
			logic        [VAL_W-1:0] pw;
			if (g == 0) begin : g_head
				assign pk = '0;
				assign pw = '0;
			end else begin : g_body
				assign pk = cell_key[g-1];
				assign pw = cell_wt[g-1];
			end

			tkr_cell u_cell (
				.clk      (clk),
				.key_in   (key_s1),
				.wt_in    (wt_s1),
				.tol      (tol_q),
				.prev_key (pk),
				.prev_wt  (pw),
				.ctrl     (cell_ctrl[g]),
				.key_out  (cell_key[g]),
				.wt_out   (cell_wt[g]),
				.flag     (cell_flag[g])
			);

			assign dup_vec[g] = (CNT_W'(g) < count_q) && cell_flag[g].match;
			assign hv_vec[g]  = (CNT_W'(g) < count_q) && cell_flag[g].heavier;
		end
	endgenerate

	// first matching key, and first entry lighter than the offer or else the first free slot
	always_comb begin
		dup_pos = '0;
		ins_pos = CNT_W'(MAX_ENTRIES);
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (dup_vec[i]) begin
				dup_pos = CNT_W'(i);
			end
			if (!hv_vec[i]) begin
				ins_pos = CNT_W'(i);
			end
		end
	end

	always_comb begin
		st_nxt  = ST_DISABLED;
		pos_nxt = '0;
		cnt_nxt = count_q;
		okey    = '0;
		owt     = '0;
		do_ins  = 1'b0;
		last    = (count_q < lim) ? count_q : lim - 1'b1;
		if (act_s1 == ACT_READ) begin
			pos_nxt = {1'b0, ridx_s1};
			if ({1'b0, ridx_s1} < count_q) begin
				st_nxt = ST_READ_OK;
				okey   = cell_key[ridx_s1];
				owt    = cell_wt[ridx_s1];
			end else begin
				st_nxt = ST_BAD_INDEX;
			end
		end else if (lim == '0) begin
			st_nxt = ST_DISABLED;
		end else if (|dup_vec) begin
			st_nxt  = ST_DUPLICATE;
			pos_nxt = dup_pos;
		end else if (ins_pos >= lim) begin
			st_nxt  = ST_LIGHT;
			pos_nxt = ins_pos;
		end else begin
			do_ins  = 1'b1;
			pos_nxt = ins_pos;
			if (count_q < lim) begin
				st_nxt  = ST_INSERTED;
				cnt_nxt = count_q + 1'b1;
			end else begin
				st_nxt = ST_DROPPED;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			cell_ctrl[j].ld_new  = commit && do_ins && (CNT_W'(j) == ins_pos);
			cell_ctrl[j].ld_prev = commit && do_ins && (CNT_W'(j) > ins_pos)
				&& (CNT_W'(j) <= last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			tol_q       <= '0;
			count_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CAPACITY: begin
						capacity_q <= cfg_data[CNT_W-1:0];
					end
					CFG_TOLERANCE: begin
						tol_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_CAPACITY) begin
				count_q <= '0;
			end else if (commit) begin
				count_q <= cnt_nxt;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (commit) begin
				vld_s1 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= action;
			key_s1  <= key_value;
			wt_s1   <= weight_value;
			ridx_s1 <= read_index;
		end
		if (commit) begin
			status_q       <= st_nxt;
			position_q     <= pos_nxt;
			entry_count_q  <= cnt_nxt;
			entry_key_q    <= okey;
			entry_weight_q <= owt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign position     = position_q;
	assign entry_count  = entry_count_q;
	assign entry_key    = entry_key_q;
	assign entry_weight = entry_weight_q;

	`TKR_ASSERT_IMP(a_count_lim, clk, arst_n, 1'b1, count_q <= lim, "count above capacity")
	`TKR_ASSERT_NXT(a_ins_count, clk, arst_n, commit && st_nxt == ST_INSERTED, count_q == $past(count_q) + 1'b1, "insert did not grow count")
	`TKR_ASSERT_NXT(a_dup_hold, clk, arst_n, commit && st_nxt == ST_DUPLICATE && !cfg_valid, $stable(count_q), "duplicate changed count")
	`TKR_ASSERT_IMP(a_no_stage_loss, clk, arst_n, vld_s1 && out_valid_q && !out_ready, !in_ready && !commit, "item stage overwritten")

	generate
		for (g = 1; g < MAX_ENTRIES; g++) begin : g_order
			`TKR_ASSERT_IMP(a_sorted, clk, arst_n, CNT_W'(g) < count_q, cell_wt[g-1] >= cell_wt[g], "list out of weight order")
		end
	endgenerate

endmodule

// ===== tb/sv/top_k_rank_with_dedup_top_test.sv =====
// ----------------------------------------------------------------------------
// Top-k rank list testbench
// Drives offers and indexed reads into the ranked list over valid/ready,
// mirrors the list in a scoreboard that ranks, de-duplicates and drops
// entries on its own, and checks every result transfer field by field.
// Capacity and tolerance are rewritten between phases once the list is idle.
// ----------------------------------------------------------------------------
module top_k_rank_with_dedup_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tkr_pkg::*;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 50;

	typedef struct {
		logic [ST_W-1:0]         status;
		logic [CNT_W-1:0]        position;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] key;
		logic [VAL_W-1:0]        weight;
	} rank_result_t;

	class rank_scoreboard;
		logic signed [VAL_W-1:0] keys[MAX_ENTRIES];
		logic [VAL_W-1:0]        weights[MAX_ENTRIES];
		int unsigned             held;
		int unsigned             cap_reg;
		logic [VAL_W-1:0]        tol;
		rank_result_t            expected_q[$];
		int                      errors;

		function void clear_state();
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				keys[i] = '0;
				weights[i] = '0;
			end
			held = 0;
			cap_reg = CAP_RESET;
			tol = '0;
			errors = 0;
			expected_q.delete();
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
			if (idx == CFG_CAPACITY) begin
				cap_reg = data[CNT_W-1:0];
				held = 0;
			end else begin
				tol = data;
			end
		endfunction

		// rank one accepted item and queue the result it must produce
		function void note_item(logic act, logic signed [VAL_W-1:0] k, logic [VAL_W-1:0] w,
				logic [IDX_W-1:0] ridx);
			rank_result_t r;
			int unsigned  lim;
			int unsigned  pos;
			int unsigned  last;
			longint       key_gap;
			bit           dup;
			lim = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
			if (held > lim)
				held = lim;
			r.position = '0;
			r.key = '0;
			r.weight = '0;
			if (act == ACT_READ) begin
				r.position = CNT_W'(ridx);
				if (ridx < held) begin
					r.status = ST_READ_OK;
					r.key = keys[ridx];
					r.weight = weights[ridx];
				end else begin
					r.status = ST_BAD_INDEX;
				end
			end else if (lim == 0) begin
				r.status = ST_DISABLED;
			end else begin
				dup = 1'b0;
				pos = 0;
				for (int i = 0; i < held && !dup; i++) begin
					key_gap = longint'(keys[i]) - longint'(k);
					if (key_gap < 0)
						key_gap = -key_gap;
					if (key_gap <= longint'(tol)) begin
						dup = 1'b1;
						pos = i;
					end
				end
				if (dup) begin
					r.status = ST_DUPLICATE;
				end else begin
					while (pos < held && weights[pos] >= w)
						pos++;
					if (pos >= lim) begin
						r.status = ST_LIGHT;
					end else begin
						last = (held < lim) ? held : lim - 1;
						for (int j = last; j > pos; j--) begin
							keys[j] = keys[j-1];
							weights[j] = weights[j-1];
						end
						keys[pos] = k;
						weights[pos] = w;
						if (held < lim) begin
							held++;
							r.status = ST_INSERTED;
						end else begin
							r.status = ST_DROPPED;
						end
					end
				end
				r.position = CNT_W'(pos);
			end
			r.count = CNT_W'(held);
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $realtime, what);
		endfunction

		function void check_result(rank_result_t got);
			rank_result_t exp_r;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with none pending: st=%0d pos=%0d cnt=%0d key=%h wt=%h",
					got.status, got.position, got.count, got.key, got.weight));
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.status !== exp_r.status || got.position !== exp_r.position ||
					got.count !== exp_r.count || got.key !== exp_r.key ||
					got.weight !== exp_r.weight)
				flag($sformatf({"mismatch exp st=%0d pos=%0d cnt=%0d key=%h wt=%h",
					" got st=%0d pos=%0d cnt=%0d key=%h wt=%h"},
					exp_r.status, exp_r.position, exp_r.count, exp_r.key, exp_r.weight,
					got.status, got.position, got.count, got.key, got.weight));
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [VAL_W-1:0]            cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        action = ACT_OFFER;
	logic signed [VAL_W-1:0]     key_value = '0;
	logic [VAL_W-1:0]            weight_value = '0;
	logic [IDX_W-1:0]            read_index = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [ST_W-1:0]             status;
	logic [CNT_W-1:0]            position;
	logic [CNT_W-1:0]            entry_count;
	logic signed [VAL_W-1:0]     entry_key;
	logic [VAL_W-1:0]            entry_weight;

	rank_scoreboard sb = new();
	bit             calm = 1'b0;
	int             hold_reqs = 0;
	int             hold_seen = 0;
	int             hold_left = 0;
	int             cycles = 0;

	top_k_rank_with_dedup_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.key_value    (key_value),
		.weight_value (weight_value),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.position     (position),
		.entry_count  (entry_count),
		.entry_key    (entry_key),
		.entry_weight (entry_weight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("top_k_rank_with_dedup_top_test: errors");
			$finish;
		end
	end

	// result side: random stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if (calm) begin
			out_ready = 1'b1;
		end else begin
			out_ready = ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin
		rank_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.position = position;
			got.count = entry_count;
			got.key = entry_key;
			got.weight = entry_weight;
			sb.check_result(got);
		end
	end

	task automatic push_item(input logic act, input logic signed [VAL_W-1:0] k,
			input logic [VAL_W-1:0] w, input logic [IDX_W-1:0] ridx);
		int gap;
		if (!calm && $urandom_range(0, 99) < 9) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		key_value = k;
		weight_value = w;
		read_index = ridx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_item(act, k, w, ridx);
		@(negedge clk);
	endtask

	task automatic offer(input logic signed [VAL_W-1:0] k, input logic [VAL_W-1:0] w);
		push_item(ACT_OFFER, k, w, IDX_W'($urandom));
	endtask

	task automatic read_at(input logic [IDX_W-1:0] ridx);
		push_item(ACT_READ, $urandom, $urandom, ridx);
	endtask

	// sender stops and waits for every pending result before going on
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// keys near held ones hit the tolerance edge from both sides
	function automatic logic signed [VAL_W-1:0] pick_key();
		int unsigned             sel;
		logic signed [VAL_W-1:0] base;
		logic signed [VAL_W-1:0] k;
		sel = $urandom_range(0, 9);
		if (sb.held != 0 && sel < 4) begin
			base = sb.keys[$urandom_range(0, sb.held - 1)];
			case (sel)
			0: k = base + sb.tol;
			1: k = base - sb.tol;
			2: k = base + sb.tol + 1;
			default: k = base - sb.tol - 1;
			endcase
		end else if (sel < 7) begin
			k = $urandom;
		end else begin
			k = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		end
		return k;
	endfunction

	function automatic logic [VAL_W-1:0] pick_weight();
		int unsigned sel;
		logic [VAL_W-1:0] w;
		sel = $urandom_range(0, 9);
		case (sel)
		0: w = '0;
		1: w = '1;
		2, 3, 4: w = $urandom_range(1, 8) << 16;
		default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic [VAL_W-1:0] pick_tolerance(int phase);
		logic [VAL_W-1:0] t;
		case (phase % 5)
		0: t = '0;
		1: t = $urandom_range(1, 32'h0004_0000);
		2: t = '1;
		3: t = $urandom;
		default: t = $urandom_range(0, 32'h0000_1000);
		endcase
		return t;
	endfunction

	initial begin
		int unsigned caps[10];
		caps = '{1, 8, 15, 0, 3, 9, 2, 5, 8, 4};
		sb.clear_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: capacity two, exact key match
		read_at(3'd0);
		offer(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		offer(32'sh8000_0000, 32'h0000_0000);
		offer(32'sh0000_0001, 32'h0000_0000);
		offer(32'sh0000_0005, 32'h0000_000A);
		offer(32'sh0000_0005, 32'h0000_0063);
		read_at(3'd0);
		read_at(3'd1);
		read_at(3'd7);
		drain();

		write_reg(CFG_CAPACITY, 32'd0);
		offer(32'sh0000_1234, 32'h0001_0000);
		read_at(3'd0);
		drain();

		// full-width tolerance: the extreme keys still collide
		write_reg(CFG_CAPACITY, 32'd8);
		write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
		offer(32'sh8000_0000, 32'h0000_0005);
		offer(32'sh7FFF_FFFF, 32'h0000_0009);
		drain();

		// capacity above the row: equal weights keep arrival order, then overflow
		write_reg(CFG_CAPACITY, 32'd15);
		write_reg(CFG_TOLERANCE, 32'h0001_0000);
		for (int i = 0; i < 9; i++)
			offer(i * 32'sh0003_0000, 32'h0001_0000);
		offer(32'sh0100_0000, 32'h0002_0000);
		read_at(3'd0);
		read_at(3'd7);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_CAPACITY, caps[ph]);
			write_reg(CFG_TOLERANCE, pick_tolerance(ph));
			calm = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 10)
					hold_reqs++;
				if ($urandom_range(0, 4) == 0) begin
					if (sb.held != 0 && $urandom_range(0, 1) == 1)
						read_at($urandom_range(0, sb.held - 1));
					else
						read_at($urandom_range(0, MAX_ENTRIES - 1));
				end else begin
					offer(pick_key(), pick_weight());
				end
			end
			calm = 1'b0;
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("top_k_rank_with_dedup_top_test: clean");
		else
			$display("top_k_rank_with_dedup_top_test: errors");
		$finish;
	end

endmodule
